// ===== sv/edfrm_pkg.sv =====
// Package with the item types, codes and controller types of the task picker.
`default_nettype none
package edfrm_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_PICK  = 2'd2;

  // Scheduling policy codes; code 3 behaves like the default policy.
  localparam logic [1:0] POL_DEFAULT = 2'd0;
  localparam logic [1:0] POL_EDF     = 2'd1;
  localparam logic [1:0] POL_RM      = 2'd2;

  localparam int unsigned PID_W      = 15;
  localparam int unsigned DEADLINE_W = 31;
  localparam int unsigned RATE_W     = 8;
  localparam int unsigned SLOT_W     = 6;

  // Input word.
  typedef struct packed {
    logic [1:0]            kind;
    logic [SLOT_W-1:0]     slot;
    logic [PID_W-1:0]      task_id;
    logic [1:0]            policy_code;
    logic [DEADLINE_W-1:0] deadline_value;
    logic [RATE_W-1:0]     rate_value;
    logic                  runnable_in;
  } in_item_t;

  // Output word.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] chosen_slot;
    logic [PID_W-1:0]  chosen_id;
  } out_item_t;

  // One task table entry; the runnable flag lives in flip-flops.
  typedef struct packed {
    logic [PID_W-1:0]      pid;
    logic [1:0]            policy;
    logic [DEADLINE_W-1:0] deadline;
    logic [RATE_W-1:0]     rate;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_CLASS,
    ST_SWEEP,
    ST_DRAIN,
    ST_COMMIT,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic do_update;
    logic scan_init;
    logic scan_step;
    logic take_scanned;
    logic class_init;
    logic sweep_rd;
    logic commit;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       scan_hit;
    logic       cnt_last;
    logic       is_class;
    logic       out_busy;
  } status_t;

  // Rate-monotonic order key: the signed weight -1 ranks lowest, so it maps to 0.
  function automatic logic [1:0] rm_rank(input logic [RATE_W-1:0] rate);
    logic [1:0] rank;
    if (rate >= RATE_W'(1) && rate < RATE_W'(11)) begin
      rank = 2'd3;
    end else if (rate >= RATE_W'(11) && rate < RATE_W'(21)) begin
      rank = 2'd2;
    end else if (rate >= RATE_W'(21) && rate < RATE_W'(31)) begin
      rank = 2'd1;
    end else begin
      rank = 2'd0;
    end
    return rank;
  endfunction

endpackage
`default_nettype wire

// ===== sv/edfrm_ctrl.sv =====
// Controller state machine of the task picker.
`default_nettype none
module edfrm_ctrl
  import edfrm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (status_i.kind == KIND_PICK) state_d = ST_SCAN;
        else                            state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (status_i.scan_hit)      state_d = ST_CLASS;
        else if (status_i.cnt_last) state_d = ST_DONE;
      end
      ST_CLASS: begin
        if (status_i.is_class) state_d = ST_SWEEP;
        else                   state_d = ST_COMMIT;
      end
      ST_SWEEP: begin
        if (status_i.cnt_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_DONE;
      ST_DONE: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.do_update = 1'b1;
        cmd_o.scan_init = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.take_scanned = status_i.scan_hit;
        cmd_o.scan_step    = !status_i.scan_hit;
      end
      ST_CLASS:  cmd_o.class_init = 1'b1;
      ST_SWEEP:  cmd_o.sweep_rd   = 1'b1;
      ST_DRAIN:  ;
      ST_COMMIT: cmd_o.commit = 1'b1;
      ST_DONE:   cmd_o.out_load = !status_i.out_busy;
      default:   ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/edfrm_dpath.sv =====
// Datapath of the task picker: task table, scan pointer, class minimum and output word.
`default_nettype none
module edfrm_dpath
  import edfrm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_data_i,
  input  wire cmd_t      cmd_i,
  output status_t        status_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  in_item_t               item_q;
  logic [TABLE_ENTRIES-1:0] runnable_q;
  logic [TABLE_ENTRIES-1:0] written_q;
  entry_t                 mem [TABLE_ENTRIES];
  entry_t                 rd_data_q;
  logic                   rd_wr_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic                   cmp_v_q;
  logic [IDX_W-1:0]       cursor_q;
  logic [IDX_W-1:0]       ptr_q;
  logic [IDX_W-1:0]       cnt_q;
  logic [IDX_W-1:0]       scanned_q;
  logic [1:0]             cls_q;
  logic                   have_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic [DEADLINE_W-1:0]  best_key_q;
  logic [PID_W-1:0]       best_pid_q;
  logic                   found_q;
  logic                   out_valid_q;
  out_item_t              out_data_q;

  logic [IDX_W-1:0]       item_idx;
  logic                   in_range;
  logic [IDX_W-1:0]       ptr_nxt;
  logic [IDX_W-1:0]       scanned_nxt;
  entry_t                 rd_entry;
  logic [DEADLINE_W-1:0]  cand_key;
  logic                   cand;
  logic                   beats;
  logic                   rd_en;

  assign item_idx    = IDX_W'(item_q.slot);
  assign in_range    = (32'(item_q.slot) < 32'(TABLE_ENTRIES));
  assign ptr_nxt     = (ptr_q == LAST_IDX) ? '0 : ptr_q + IDX_W'(1);
  assign scanned_nxt = (scanned_q == LAST_IDX) ? '0 : scanned_q + IDX_W'(1);
  assign rd_en       = cmd_i.take_scanned | cmd_i.sweep_rd;

  // An entry that was never written reads as all zero.
  assign rd_entry = rd_wr_q ? rd_data_q : '0;

  // Order key of the entry under compare and its test against the best so far.
  assign cand_key = (cls_q == POL_EDF) ? rd_entry.deadline
                                       : DEADLINE_W'(rm_rank(rd_entry.rate));
  assign cand  = cmp_v_q && runnable_q[rd_idx_q] && (rd_entry.policy == cls_q);
  assign beats = (cand_key < best_key_q) ||
                 ((cand_key == best_key_q) && (rd_entry.pid < best_pid_q));

  // Item register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
  end

  // Table payload memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_update && item_q.kind == KIND_WRITE && in_range) begin
      mem[item_idx] <= '{pid:      item_q.task_id,
                         policy:   item_q.policy_code,
                         deadline: item_q.deadline_value,
                         rate:     item_q.rate_value};
    end
    if (rd_en) begin
      rd_data_q <= mem[ptr_q];
      rd_idx_q  <= ptr_q;
    end
  end

  // Runnable flags, written flags and read tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      runnable_q <= '0;
      written_q  <= '0;
      rd_wr_q    <= 1'b0;
      cmp_v_q    <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.sweep_rd;
      if (rd_en) rd_wr_q <= written_q[ptr_q];
      if (cmd_i.do_update && in_range &&
          (item_q.kind == KIND_WRITE || item_q.kind == KIND_SET)) begin
        runnable_q[item_idx] <= item_q.runnable_in;
      end
      if (cmd_i.do_update && in_range && item_q.kind == KIND_WRITE) begin
        written_q[item_idx] <= 1'b1;
      end
      if (cmd_i.commit) runnable_q[best_idx_q] <= 1'b0;
    end
  end

  // Scan cursor, walking pointer and step count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q  <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      scanned_q <= '0;
      found_q   <= 1'b0;
    end else begin
      if (cmd_i.scan_init) begin
        ptr_q <= cursor_q;
        cnt_q <= '0;
      end else if (cmd_i.class_init) begin
        ptr_q <= '0;
        cnt_q <= '0;
      end else if (cmd_i.scan_step || cmd_i.sweep_rd) begin
        ptr_q <= ptr_nxt;
        cnt_q <= cnt_q + IDX_W'(1);
      end
      if (cmd_i.take_scanned) scanned_q <= ptr_q;
      if (cmd_i.load_item) begin
        found_q <= 1'b0;
      end else if (cmd_i.commit) begin
        found_q  <= 1'b1;
        cursor_q <= scanned_nxt;
      end
    end
  end

  // Best candidate: seeded from the scanned slot, then refined over the sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.class_init) begin
      have_q <= 1'b0;
    end else if (cand) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.class_init) begin
      cls_q      <= rd_entry.policy;
      best_idx_q <= scanned_q;
      best_pid_q <= rd_entry.pid;
      best_key_q <= '0;
    end else if (cand && (!have_q || beats)) begin
      best_idx_q <= rd_idx_q;
      best_pid_q <= rd_entry.pid;
      best_key_q <= cand_key;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.found       <= found_q;
      out_data_q.chosen_slot <= found_q ? SLOT_W'(best_idx_q) : '0;
      out_data_q.chosen_id   <= found_q ? best_pid_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Status to the controller.
  always_comb begin
    status_o.kind     = item_q.kind;
    status_o.scan_hit = runnable_q[ptr_q];
    status_o.cnt_last = (cnt_q == LAST_IDX);
    status_o.is_class = (rd_entry.policy == POL_EDF) || (rd_entry.policy == POL_RM);
    status_o.out_busy = out_valid_q && !out_ready_i;
  end

endmodule
`default_nettype wire

// ===== sv/edf_rm_task_picker_core.sv =====
// Task picker with a mixed default / EDF / rate-monotonic policy: top level.
//
// Usage: items arrive on the in_valid_i / in_ready_o channel as one in_item_t word;
// each produces exactly one out_item_t word on out_valid_o / out_ready_i.
// A write loads a table slot, a set changes a slot's runnable flag, and a pick
// returns the chosen task and clears its runnable flag.
// A write or set passes through the decode state to the done state, where its
// result word is loaded into the output register.
// A pick first walks the runnable flags from the scan cursor, one slot per cycle
// (up to TABLE_ENTRIES slots); for an EDF or RM pick it then sweeps the whole
// table through the single read port of the table memory, one entry per cycle.
// A pick that finds a runnable slot then commits its choice, and every pick
// loads its word in the done state.
// One item is in flight at a time; in_ready_o is high while idle.
// The result sits in an output register, so the next item is taken while the
// previous word still waits; a stalled receiver holds that word, and the next
// result waits inside the block until the output register is free.
// Reset clears the runnable flags, the scan cursor and the output valid at once;
// slots never written read as all zero, so no clearing pass is needed.
`default_nettype none
module edf_rm_task_picker_core
  import edfrm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencing.
  edfrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Table, search and output word.
  edfrm_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== bench/edf_picker_checker.sv =====
// Checker for the task picker: keeps its own task table, predicts each result word and compares.
module edf_picker_checker
  import edfrm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_ready_i,
  input  wire in_item_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_ready_i,
  input  wire out_item_t out_data_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);

  localparam int unsigned SLOTS = 1 << SLOT_W;

  // Shadow copy of the task table and the scan cursor.
  logic                  runnable_tab [SLOTS];
  logic [1:0]            policy_tab   [SLOTS];
  logic [DEADLINE_W-1:0] deadline_tab [SLOTS];
  logic [RATE_W-1:0]     rate_tab     [SLOTS];
  logic [PID_W-1:0]      pid_tab      [SLOTS];
  logic [SLOT_W-1:0]     cursor;

  // Picks and acknowledgements still owed by the block, oldest first.
  out_item_t   owed_words [$];
  out_item_t   predicted;
  out_item_t   oldest;
  int unsigned mismatches;

  // Signed rate-monotonic weight; anything outside 1..30 ranks as -1.
  function automatic int rate_weight(input logic [RATE_W-1:0] rate);
    if (rate >= 1 && rate <= 10) return 3;
    if (rate >= 11 && rate <= 20) return 2;
    if (rate >= 21 && rate <= 30) return 1;
    return -1;
  endfunction

  // True when slot a should displace the current best slot b within class cls.
  function automatic bit outranks(input int unsigned a, input int unsigned b,
                                  input logic [1:0] cls);
    int wa;
    int wb;
    if (cls == POL_EDF) begin
      if (deadline_tab[a] != deadline_tab[b]) return deadline_tab[a] < deadline_tab[b];
    end else begin
      wa = rate_weight(rate_tab[a]);
      wb = rate_weight(rate_tab[b]);
      if (wa != wb) return wa < wb;
    end
    return pid_tab[a] < pid_tab[b];
  endfunction

  // Apply one input word to the shadow table and work out the word it produces.
  task automatic pick_or_update(input in_item_t w, output out_item_t res);
    int unsigned scanned;
    int unsigned best;
    int unsigned s;
    logic [1:0]  cls;
    bit          hit;
    bit          have;
    res = '0;
    case (w.kind)
      KIND_WRITE: begin
        pid_tab[w.slot]      = w.task_id;
        policy_tab[w.slot]   = w.policy_code;
        deadline_tab[w.slot] = w.deadline_value;
        rate_tab[w.slot]     = w.rate_value;
        runnable_tab[w.slot] = w.runnable_in;
      end
      KIND_SET: begin
        runnable_tab[w.slot] = w.runnable_in;
      end
      KIND_PICK: begin
        hit = 1'b0;
        scanned = 0;
        for (int i = 0; i < SLOTS && !hit; i++) begin
          s = (cursor + i) % SLOTS;
          if (runnable_tab[s]) begin
            scanned = s;
            hit = 1'b1;
          end
        end
        if (hit) begin
          best = scanned;
          cls = policy_tab[scanned];
          // EDF and RM look over the whole class; the first member seeds the search.
          if (cls == POL_EDF || cls == POL_RM) begin
            have = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
              if (runnable_tab[i] && policy_tab[i] == cls) begin
                if (!have || outranks(i, best, cls)) begin
                  best = i;
                  have = 1'b1;
                end
              end
            end
          end
          runnable_tab[best] = 1'b0;
          cursor = SLOT_W'((scanned + 1) % SLOTS);
          res.found = 1'b1;
          res.chosen_slot = SLOT_W'(best);
          res.chosen_id = pid_tab[best];
        end
      end
      default: begin
      end
    endcase
  endtask

  // Compare finished words against the oldest prediction, then predict newly taken ones.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        runnable_tab[i] = 1'b0;
        policy_tab[i]   = '0;
        deadline_tab[i] = '0;
        rate_tab[i]     = '0;
        pid_tab[i]      = '0;
      end
      cursor = '0;
      owed_words.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %p", $time, out_data_i);
          mismatches++;
        end else begin
          oldest = owed_words.pop_front();
          if (out_data_i.found !== oldest.found) begin
            $display("%0t: found expected %0d got %0d", $time, oldest.found,
                     out_data_i.found);
            mismatches++;
          end
          if (out_data_i.chosen_slot !== oldest.chosen_slot) begin
            $display("%0t: chosen_slot expected %0d got %0d", $time, oldest.chosen_slot,
                     out_data_i.chosen_slot);
            mismatches++;
          end
          if (out_data_i.chosen_id !== oldest.chosen_id) begin
            $display("%0t: chosen_id expected %0d got %0d", $time, oldest.chosen_id,
                     out_data_i.chosen_id);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pick_or_update(in_data_i, predicted);
        owed_words.push_back(predicted);
      end
      fail_count_o <= mismatches;
      pending_o <= owed_words.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the task picker bench: clock, reset, stimulus, back-pressure, watchdog and verdict.
module tb_top;
  import edfrm_pkg::*;

  // The spare item kind is ignored; policy code 3 acts like the default policy.
  localparam logic [1:0]  KIND_UNUSED    = 2'd3;
  localparam logic [1:0]  POL_ALT        = 2'd3;
  localparam int unsigned RANDOM_ITEMS   = 1250;
  localparam int unsigned PHASE_ITEMS    = 250;
  localparam int unsigned SETTLE_CYCLES  = 150;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_word = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_word;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned next_stall;
  int unsigned sent = 0;
  bit          quiet = 1'b0;

  always #1 clk = ~clk;

  edf_rm_task_picker_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  edf_picker_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver: after each word it takes, it may drop ready for a random stall; in the quiet phase it never stalls.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      next_stall = quiet ? 0 : $urandom_range(3);
      stall_left <= next_stall;
      out_ready <= (next_stall == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: too many cycles with no word moving on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic in_item_t make_word(input logic [1:0] kind, input logic [SLOT_W-1:0] slot,
                                         input logic [PID_W-1:0] pid, input logic [1:0] pol,
                                         input logic [DEADLINE_W-1:0] deadline,
                                         input logic [RATE_W-1:0] rate, input logic run);
    in_item_t w;
    w.kind = kind;
    w.slot = slot;
    w.task_id = pid;
    w.policy_code = pol;
    w.deadline_value = deadline;
    w.rate_value = rate;
    w.runnable_in = run;
    return w;
  endfunction

  // Fully random word, any kind; also the base for slot load words.
  function automatic in_item_t noise_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  // A slot load biased towards ties, rate bucket edges and runnable tasks.
  function automatic in_item_t task_load_word();
    in_item_t    w;
    int unsigned p;
    int unsigned d;
    w = noise_word();
    w.kind = KIND_WRITE;
    w.task_id = $urandom_range(1) ? PID_W'($urandom_range(7)) : PID_W'($urandom_range(32767));
    p = $urandom_range(19);
    if (p == 0) begin
      w.policy_code = POL_ALT;
    end else if (p < 7) begin
      w.policy_code = POL_DEFAULT;
    end else if (p < 13) begin
      w.policy_code = POL_EDF;
    end else begin
      w.policy_code = POL_RM;
    end
    d = $urandom_range(9);
    if (d < 4) begin
      w.deadline_value = DEADLINE_W'($urandom_range(15));
    end else if (d == 4) begin
      w.deadline_value = '1;
    end
    if ($urandom_range(4) < 3) w.rate_value = RATE_W'($urandom_range(40));
    w.runnable_in = ($urandom_range(9) != 0);
    return w;
  endfunction

  // Offer one word after a random gap and hold it until the block takes it.
  task automatic send_word(input in_item_t w);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.kind != KIND_UNUSED) sent++;
  endtask

  // Stop sending until every owed result word has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    phase = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, ignored kind, wrap of the scan, ties and class searches.
    send_word(make_word(KIND_PICK, 0, 0, POL_DEFAULT, 0, 0, 0));
    send_word(make_word(KIND_UNUSED, 63, 15'h7FFF, POL_ALT, '1, 8'hFF, 1));
    send_word(make_word(KIND_WRITE, 63, 15'h7FFF, POL_DEFAULT, '1, 8'hFF, 1));
    send_word(make_word(KIND_PICK, 0, 0, POL_DEFAULT, 0, 0, 0));
    send_word(make_word(KIND_WRITE, 5, 7, POL_EDF, 100, 0, 1));
    send_word(make_word(KIND_WRITE, 9, 3, POL_EDF, 100, 0, 1));
    send_word(make_word(KIND_WRITE, 20, 1, POL_EDF, '1, 0, 1));
    send_word(make_word(KIND_WRITE, 0, 0, POL_EDF, 0, 0, 0));
    send_word(make_word(KIND_PICK, 0, 0, POL_DEFAULT, 0, 0, 0));
    send_word(make_word(KIND_WRITE, 30, 10, POL_RM, 0, 0, 1));
    send_word(make_word(KIND_WRITE, 31, 2, POL_RM, 0, 5, 1));
    send_word(make_word(KIND_WRITE, 32, 10, POL_RM, 0, 31, 1));
    send_word(make_word(KIND_WRITE, 33, 0, POL_RM, 0, 15, 1));
    send_word(make_word(KIND_WRITE, 34, 4, POL_RM, 0, 25, 1));
    send_word(make_word(KIND_SET, 20, 0, POL_DEFAULT, 0, 0, 0));
    send_word(make_word(KIND_SET, 20, 0, POL_DEFAULT, 0, 0, 1));
    repeat (3) send_word(make_word(KIND_PICK, 0, 0, POL_DEFAULT, 0, 0, 0));
    send_word(make_word(KIND_WRITE, 40, 15'h1234, POL_ALT, 7, 10, 1));
    send_word(make_word(KIND_SET, 50, 0, POL_DEFAULT, 0, 0, 1));
    send_word(make_word(KIND_SET, 0, 0, POL_DEFAULT, 0, 0, 1));
    repeat (3) send_word(make_word(KIND_PICK, 63, 0, POL_DEFAULT, 0, 0, 0));
    wait_drain();

    // Random: mostly load-then-pick rounds, some noise; the middle phase runs flat out.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        n = $urandom_range(1, 8);
        repeat (n) send_word(task_load_word());
        if ($urandom_range(3) == 0) begin
          send_word(make_word(KIND_SET, SLOT_W'($urandom_range(63)), 0, POL_DEFAULT, 0, 0,
                              1'($urandom_range(1))));
        end
        repeat ($urandom_range(1, n + 2)) begin
          send_word(make_word(KIND_PICK, SLOT_W'($urandom_range(63)),
                              PID_W'($urandom_range(32767)), 2'($urandom_range(3)),
                              DEADLINE_W'($urandom), RATE_W'($urandom_range(255)),
                              1'($urandom_range(1))));
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_word(noise_word());
      end
      if (sent >= (phase + 1) * PHASE_ITEMS) begin
        wait_drain();
        phase++;
        quiet = (phase == 2);
      end
    end

    quiet = 1'b0;
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
